// ===== sv/rhc_pkg.sv =====
// shared types and constants of the rgb to hsl/hsv converter
package rhc_pkg;

   localparam int CHANNEL_BITS = 16;
   localparam int OUT_BITS = 12;
   localparam int QUO_BITS = 12;
   localparam int DVS_BITS = 18;
   localparam int DIVIDEND_BITS = 46;
   localparam int CELL_COUNT = QUO_BITS;

   localparam logic [1:0] MODE_HSL = 2'd0;
   localparam logic [1:0] MODE_HSV = 2'd1;

   // 255 * 16 * 2 and 60 / 2 * 16 * 2, doubled for round to nearest
   localparam logic [12:0] SCALE_X2 = 13'd8160;
   localparam logic [9:0] HUE_X2 = 10'd960;
   localparam logic [OUT_BITS-1:0] OUT_MAX = 12'd4095;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] first_component;
      logic [OUT_BITS-1:0] second_component;
      logic [OUT_BITS-1:0] third_component;
   } rsp_type;

   // one restoring divider lane: partial remainder, dividend bits still to shift in
   typedef struct packed {
      logic [DVS_BITS-1:0] rem;
      logic [QUO_BITS-1:0] low;
      logic [QUO_BITS-1:0] quo;
      logic [DVS_BITS-1:0] dvs;
   } lane_type;

   typedef struct packed {
      logic                valid;
      logic                use_rgb;
      logic                grey;
      logic                hue_ovf;
      logic                sat_ovf;
      logic [OUT_BITS-1:0] c0;
      logic [OUT_BITS-1:0] c1;
      logic [OUT_BITS-1:0] c2;
   } side_type;

   typedef struct packed {
      side_type side;
      lane_type hue;
      lane_type sat;
   } stage_type;

endpackage

// ===== sv/rhc_front.sv =====
// front stages: min/max, hue sector, dividend and divisor setup, overflow check
module rhc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  rhc_pkg::req_type in_data,
   input  logic [1:0]       mode,
   output rhc_pkg::stage_type out_stage
);

   typedef struct packed {
      logic        valid;
      logic [1:0]  mode;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [15:0] mx;
      logic [15:0] mn;
      logic [15:0] d;
   } s1_type;

   typedef struct packed {
      logic        valid;
      logic        use_rgb;
      logic        grey;
      logic [45:0] hx;
      logic [17:0] hy;
      logic [45:0] sx;
      logic [17:0] sy;
      logic [11:0] c0;
      logic [11:0] c1;
      logic [11:0] c2;
   } s2_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   rhc_pkg::stage_type s3_ff, s3_in;

   logic [15:0] mx, mn;
   logic [18:0] n;
   logic [16:0] sum, den;
   logic [28:0] r_sc, g_sc, b_sc, mx_sc;
   logic [29:0] sum_sc;
   logic [28:0] d_sc;
   logic        hovf, sovf;

   always_comb begin
      mx = in_data.red_in;
      mn = in_data.red_in;
      if (in_data.green_in > mx) mx = in_data.green_in;
      if (in_data.blue_in > mx) mx = in_data.blue_in;
      if (in_data.green_in < mn) mn = in_data.green_in;
      if (in_data.blue_in < mn) mn = in_data.blue_in;
      s1_in.valid = in_valid;
      s1_in.mode = mode;
      s1_in.r = in_data.red_in;
      s1_in.g = in_data.green_in;
      s1_in.b = in_data.blue_in;
      s1_in.mx = mx;
      s1_in.mn = mn;
      s1_in.d = mx - mn;
   end

   always_comb begin
      // hue in sixths of a turn times d, red checked first, then green
      if (s1_ff.mx == s1_ff.r) begin
         if (s1_ff.g >= s1_ff.b) n = 19'(s1_ff.g - s1_ff.b);
         else n = 19'(19'(s1_ff.d) * 19'd6 - 19'(s1_ff.b - s1_ff.g));
      end else if (s1_ff.mx == s1_ff.g) begin
         n = 19'(19'(s1_ff.d) * 19'd2 + 19'(s1_ff.b) - 19'(s1_ff.r));
      end else begin
         n = 19'(19'(s1_ff.d) * 19'd4 + 19'(s1_ff.r) - 19'(s1_ff.g));
      end
      sum = 17'(s1_ff.mx) + 17'(s1_ff.mn);
      den = (sum <= 17'd65536) ? sum : 17'(18'd131072 - 18'(sum));
      r_sc = 29'(29'(s1_ff.r) * 29'(rhc_pkg::SCALE_X2) + 29'd65536);
      g_sc = 29'(29'(s1_ff.g) * 29'(rhc_pkg::SCALE_X2) + 29'd65536);
      b_sc = 29'(29'(s1_ff.b) * 29'(rhc_pkg::SCALE_X2) + 29'd65536);
      mx_sc = 29'(29'(s1_ff.mx) * 29'(rhc_pkg::SCALE_X2) + 29'd65536);
      sum_sc = 30'(30'(sum) * 30'(rhc_pkg::SCALE_X2) + 30'd131072);
      d_sc = 29'(29'(s1_ff.d) * 29'(rhc_pkg::SCALE_X2));

      s2_in.valid = s1_ff.valid;
      s2_in.use_rgb = (s1_ff.mode != rhc_pkg::MODE_HSL) && (s1_ff.mode != rhc_pkg::MODE_HSV);
      s2_in.grey = (s1_ff.d == 16'd0);
      s2_in.hx = 46'(46'(n) * 46'(rhc_pkg::HUE_X2) + 46'(s1_ff.d));
      s2_in.hy = 18'({s1_ff.d, 1'b0});
      if (s1_ff.mode == rhc_pkg::MODE_HSL) begin
         s2_in.sx = 46'({d_sc, 16'd0}) + 46'(den);
         s2_in.sy = {den, 1'b0};
         s2_in.c2 = sum_sc[29:18];
      end else begin
         s2_in.sx = 46'(d_sc) + 46'(s1_ff.mx);
         s2_in.sy = 18'({s1_ff.mx, 1'b0});
         s2_in.c2 = mx_sc[28:17];
      end
      s2_in.c0 = r_sc[28:17];
      s2_in.c1 = g_sc[28:17];
      if (s2_in.use_rgb) s2_in.c2 = b_sc[28:17];
   end

   always_comb begin
      // quotient of 4096 or more saturates, else the upper bits start the remainder
      hovf = s2_ff.hx[45:12] >= 34'(s2_ff.hy);
      sovf = s2_ff.sx[45:12] >= 34'(s2_ff.sy);
      s3_in.side.valid = s2_ff.valid;
      s3_in.side.use_rgb = s2_ff.use_rgb;
      s3_in.side.grey = s2_ff.grey;
      s3_in.side.hue_ovf = hovf;
      s3_in.side.sat_ovf = sovf;
      s3_in.side.c0 = s2_ff.c0;
      s3_in.side.c1 = s2_ff.c1;
      s3_in.side.c2 = s2_ff.c2;
      s3_in.hue.rem = s2_ff.hx[29:12];
      s3_in.hue.low = s2_ff.hx[11:0];
      s3_in.hue.quo = '0;
      s3_in.hue.dvs = s2_ff.hy;
      s3_in.sat.rem = s2_ff.sx[29:12];
      s3_in.sat.low = s2_ff.sx[11:0];
      s3_in.sat.quo = '0;
      s3_in.sat.dvs = s2_ff.sy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.side.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign out_stage = s3_ff;

endmodule

// ===== sv/rhc_cell.sv =====
// one divider cell: a quotient bit for the hue lane and the saturation lane
module rhc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  rhc_pkg::stage_type in_stage,
   output rhc_pkg::stage_type out_stage
);

   rhc_pkg::stage_type stage_ff, stage_in;

   function automatic rhc_pkg::lane_type step(input rhc_pkg::lane_type l);
      rhc_pkg::lane_type o;
      logic [18:0] t;
      logic        ge;
      t = {l.rem, l.low[11]};
      ge = t >= {1'b0, l.dvs};
      o.rem = ge ? 18'(t - {1'b0, l.dvs}) : t[17:0];
      o.low = {l.low[10:0], 1'b0};
      o.quo = {l.quo[10:0], ge};
      o.dvs = l.dvs;
      return o;
   endfunction

   always_comb begin
      stage_in.side = in_stage.side;
      stage_in.hue = step(in_stage.hue);
      stage_in.sat = step(in_stage.sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.side.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

// ===== sv/rgb_to_hsl_hsv_converter.sv =====
// top level: mode register, front stages, divider cell chain and output register
// Converts one pixel per clock unless rsp_stall holds the pipeline. A transaction
// accepted on req_ passes 16 register stages to rsp_: three front stages (min/max,
// dividend setup, overflow check), twelve divider cells that each settle one quotient
// bit of hue and saturation, and the output register. The whole pipeline holds when a
// finished result is stalled, so req_stall follows rsp_stall while rsp_valid is high.
// The user writes color_mode via csr_ only while idle; the block does not enforce it.
module rgb_to_hsl_hsv_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rhc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   logic [1:0] mode_ff, mode_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rhc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic       advance;

   rhc_pkg::stage_type chain [rhc_pkg::CELL_COUNT+1];
   rhc_pkg::stage_type last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign mode_in = (csr_valid && csr_ready) ? csr_data : mode_ff;

   rhc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_data  (req_data),
      .mode     (mode_ff),
      .out_stage(chain[0])
   );

   for (genvar i = 0; i < rhc_pkg::CELL_COUNT; i++) begin : g_cell
      rhc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_stage (chain[i]),
         .out_stage(chain[i+1])
      );
   end

   assign last = chain[rhc_pkg::CELL_COUNT];

   always_comb begin
      rsp_valid_in = last.side.valid;
      if (last.side.use_rgb) begin
         rsp_data_in.first_component = last.side.c0;
         rsp_data_in.second_component = last.side.c1;
      end else if (last.side.grey) begin
         rsp_data_in.first_component = '0;
         rsp_data_in.second_component = '0;
      end else begin
         rsp_data_in.first_component = last.side.hue_ovf ? rhc_pkg::OUT_MAX : last.hue.quo;
         rsp_data_in.second_component = last.side.sat_ovf ? rhc_pkg::OUT_MAX : last.sat.quo;
      end
      rsp_data_in.third_component = last.side.c2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rhc_pkg::MODE_HSL;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         if (advance) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   a_enter_front: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> u_front.s1_ff.valid)
      else $error("accepted transaction lost at front");

   a_third_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.third_component <= 12'd4080)
      else $error("third component out of range");

endmodule
